// ===== rtl/core/aubc_pkg.sv =====
// shared types and constants of the adam update core
package aubc_pkg;

    localparam int unsigned IDX_W = 6;
    localparam int unsigned CFG_W = 48;

    typedef enum logic [1:0] {
        CFG_FIRST_DECAY  = 2'd0,
        CFG_SECOND_DECAY = 2'd1,
        CFG_STEP_RATE    = 2'd2,
        CFG_ROOT_OFFSET  = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_UPDATE = 2'd1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_UPD,
        OP_READ,
        OP_SKIP
    } t_op;

    typedef struct packed {
        logic [1:0]        func;
        logic [IDX_W-1:0]  index;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic signed [31:0] gradient;
        logic              grad_valid;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]   out_index;
        logic signed [31:0] position;
        logic               overflow;
    } t_out;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   index;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic signed [31:0] gradient;
    } t_job;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] m;
        logic [47:0]        v;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_row;

endpackage

// ===== rtl/core/aubc_front.sv =====
// front end: classifies accepted items and queues them for the back end
module aubc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  aubc_pkg::t_in i_item,
    input  logic          i_pop,
    output logic          o_empty,
    output aubc_pkg::t_job o_head
);
    import aubc_pkg::*;

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       job;
    logic       push;

    always_comb begin
        job.index       = i_item.index;
        job.lower_bound = i_item.lower_bound;
        job.upper_bound = i_item.upper_bound;
        job.gradient    = i_item.gradient;
        priority if (i_item.func == FUNC_LOAD) begin
            job.op = OP_LOAD;
        end else if (i_item.func == FUNC_UPDATE) begin
            job.op = i_item.grad_valid ? OP_UPD : OP_SKIP;
        end else begin
            job.op = OP_READ;
        end
    end

    assign busy    = (r_cnt == 2'd2);
    assign push    = start && !busy;
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/core/aubc_sqrt.sv =====
// bit-serial integer square root, one root bit per cycle
module aubc_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [62:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_x;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    assign rem_sh = {r_rem[32:0], r_x[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= {1'b0, i_radicand};
                r_rem  <= 35'd0;
                r_root <= 32'd0;
                r_cnt  <= 5'd31;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_x <= {r_x[61:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/aubc_div.sv =====
// restoring divider, one quotient bit per cycle
module aubc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [62:0] i_num,
    input  logic [36:0] i_den,
    output logic        o_done,
    output logic [62:0] o_quot
);
    logic [62:0] r_n;
    logic [62:0] r_quot;
    logic [36:0] r_den;
    logic [37:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [37:0] rem_sh;

    assign rem_sh = {r_rem[36:0], r_n[62]};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= i_num;
                r_den  <= i_den;
                r_rem  <= 38'd0;
                r_quot <= 63'd0;
                r_cnt  <= 6'd62;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_n <= {r_n[61:0], 1'b0};
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem  <= rem_sh - {1'b0, r_den};
                    r_quot <= {r_quot[61:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_quot <= {r_quot[61:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/adam_update_with_bound_clamp_core.sv =====
// adam update core: entry memory, update sequencer and result register
//
// Each accepted beat yields exactly one result beat, strobed on o_valid for a single
// cycle; the receiver cannot stall it. Beats pass a two-entry queue, so busy rises only
// when two items wait. A load or read goes from the queue head through S_RD and S_EXE
// to the result register; an update with a valid gradient goes on through S_M2 to S_V3
// and S_SQ0, then the 32-step square root and the 63-step divider that run one bit per
// cycle. Items are worked one at a time in arrival order. No clearing pass after reset.
module adam_update_with_bound_clamp_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  aubc_pkg::t_in              i_item,
    output logic                       o_valid,
    output aubc_pkg::t_out             o_result,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [aubc_pkg::CFG_W-1:0] i_cfg_wdata
);
    import aubc_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NIDX = 2 ** IDX_W;

    typedef logic [AW-1:0] t_ent_tbl [NIDX];

    function automatic t_ent_tbl mk_tbl();
        t_ent_tbl t;
        for (int i = 0; i < NIDX; i++) begin
            t[i] = AW'(i % MAX_ENTRIES);
        end
        return t;
    endfunction

    localparam t_ent_tbl ENT_TBL = mk_tbl();

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v, output logic ov);
        ov = 1'b0;
        if (v > 36'sd2147483647) begin
            ov = 1'b1;
            return 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            ov = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_EXE, S_M2, S_M3, S_V1, S_V2, S_V3, S_SQ0, S_SQ, S_DV
    } t_state;

    t_state r_state;
    logic [15:0] r_b1;
    logic [15:0] r_b2;
    logic [31:0] r_rate;
    logic [47:0] r_eps;

    t_row mem [MAX_ENTRIES];
    t_row r_rdata;
    logic [AW-1:0] r_addr;
    logic mem_we;
    t_row mem_wdata;

    t_job r_cur;
    logic signed [48:0] r_pa;
    logic signed [49:0] r_pb;
    logic [63:0] r_gsq;
    logic [47:0] r_g2;
    logic [63:0] r_va;
    logic [64:0] r_vb;
    logic signed [31:0] r_m;
    logic [47:0] r_v;
    logic [62:0] r_num;
    logic r_ov;
    logic r_valid;
    t_out r_res;

    logic q_empty;
    t_job q_head;
    logic pop;
    logic sq_start;
    logic sq_done;
    logic [31:0] sq_root;
    logic dv_start;
    logic dv_done;
    logic [62:0] dv_quot;
    logic [36:0] dv_den;

    logic [16:0] c1;
    logic [16:0] c2;
    logic signed [50:0] msum;
    logic signed [35:0] mq;
    logic signed [31:0] m_new;
    logic m_ov;
    logic [31:0] g_abs;
    logic [31:0] m_abs;
    logic [65:0] vsum;
    logic [48:0] s_eps;
    logic [33:0] d_step;
    logic signed [35:0] p_next;
    logic signed [31:0] p_new;
    logic p_ov;
    logic signed [31:0] clamped;

    aubc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    aubc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand ({s_eps, 14'd0}),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    aubc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (r_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    assign c1 = 17'h10000 - {1'b0, r_b1};
    assign c2 = 17'h10000 - {1'b0, r_b2};
    assign msum = 51'(r_pa) + 51'(r_pb);
    assign mq = 36'($signed(msum[50:16]));
    assign g_abs = r_cur.gradient[31] ? 32'(-r_cur.gradient) : r_cur.gradient;
    assign m_abs = r_m[31] ? 32'(-r_m) : r_m;
    assign vsum = {2'b00, r_va} + {1'b0, r_vb};
    assign s_eps = {1'b0, r_v} + {1'b0, r_eps};
    assign dv_den = {((sq_root == 32'd0) ? 32'd1 : sq_root), 5'd0};
    assign d_step = (dv_quot > 63'h2_0000_0000) ? 34'h2_0000_0000 : dv_quot[33:0];
    assign p_next = (r_m > 32'sd0) ? 36'(r_rdata.pos) - 36'($signed({2'b00, d_step}))
                  : (r_m < 32'sd0) ? 36'(r_rdata.pos) + 36'($signed({2'b00, d_step}))
                  : 36'(r_rdata.pos);

    always_comb begin
        m_new = sat32(mq, m_ov);
        p_new = sat32(p_next, p_ov);
        clamped = r_rdata.pos;
        if (clamped < r_rdata.lo) begin
            clamped = r_rdata.lo;
        end
        if (clamped > r_rdata.hi) begin
            clamped = r_rdata.hi;
        end
    end

    assign pop      = (r_state == S_IDLE) && !q_empty;
    assign sq_start = (r_state == S_SQ0);
    assign dv_start = (r_state == S_SQ) && sq_done;

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_rdata;
        if (r_state == S_EXE && r_cur.op == OP_LOAD) begin
            mem_we    = 1'b1;
            mem_wdata = '{pos: r_cur.lower_bound, m: 32'sd0, v: 48'd0,
                          lo: r_cur.lower_bound, hi: r_cur.upper_bound};
        end else if (r_state == S_DV && dv_done) begin
            mem_we    = 1'b1;
            mem_wdata = '{pos: p_new, m: r_m, v: r_v, lo: r_rdata.lo, hi: r_rdata.hi};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1   <= 16'd58982;
            r_b2   <= 16'd65470;
            r_rate <= 32'd16777;
            r_eps  <= 48'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_FIRST_DECAY:  r_b1   <= i_cfg_wdata[15:0];
                CFG_SECOND_DECAY: r_b2   <= i_cfg_wdata[15:0];
                CFG_STEP_RATE:    r_rate <= i_cfg_wdata[31:0];
                CFG_ROOT_OFFSET:  r_eps  <= i_cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!q_empty) begin
                        r_cur   <= q_head;
                        r_addr  <= ENT_TBL[q_head.index];
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_EXE;
                S_EXE: begin
                    r_res.out_index <= r_cur.index;
                    r_res.overflow  <= 1'b0;
                    r_ov            <= 1'b0;
                    unique case (r_cur.op)
                        OP_LOAD: begin
                            r_res.position <= r_cur.lower_bound;
                            r_valid        <= 1'b1;
                            r_state        <= S_IDLE;
                        end
                        OP_SKIP: begin
                            r_res.position <= r_rdata.pos;
                            r_valid        <= 1'b1;
                            r_state        <= S_IDLE;
                        end
                        OP_READ: begin
                            r_res.position <= clamped;
                            r_valid        <= 1'b1;
                            r_state        <= S_IDLE;
                        end
                        OP_UPD: begin
                            r_pa    <= $signed({1'b0, r_b1}) * r_rdata.m;
                            r_state <= S_M2;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_M2: begin
                    r_pb    <= $signed({1'b0, c1}) * r_cur.gradient;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_m     <= m_new;
                    r_ov    <= m_ov;
                    r_gsq   <= g_abs * g_abs;
                    r_state <= S_V1;
                end
                S_V1: begin
                    if (r_gsq[63:56] != 8'd0) begin
                        r_g2 <= 48'hffff_ffff_ffff;
                        r_ov <= 1'b1;
                    end else begin
                        r_g2 <= r_gsq[55:8];
                    end
                    r_va    <= r_b2 * r_rdata.v;
                    r_state <= S_V2;
                end
                S_V2: begin
                    r_vb    <= c2 * r_g2;
                    r_state <= S_V3;
                end
                S_V3: begin
                    r_v     <= vsum[63:16];
                    r_state <= S_SQ0;
                end
                S_SQ0: begin
                    r_num   <= 63'(64'(r_rate) * 64'(m_abs));
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (sq_done) begin
                        r_state <= S_DV;
                    end
                end
                S_DV: begin
                    if (dv_done) begin
                        r_res.position <= p_new;
                        r_res.overflow <= r_ov | p_ov;
                        r_valid        <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ===== tb/aubc_scoreboard.sv =====
// checker for the adam update core: predicts every result beat and compares it
`timescale 1ns / 1ps
module aubc_scoreboard (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  aubc_pkg::t_in              i_item,
    input  logic                       o_valid,
    input  aubc_pkg::t_out             o_result,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [aubc_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_beats_in,
    output int                         o_beats_out,
    output int                         o_saturated
);
    import aubc_pkg::*;

    localparam logic [47:0] V_MAX = 48'hFFFF_FFFF_FFFF;

    logic [15:0]        beta1, beta2;
    logic [31:0]        rate;
    logic [47:0]        eps;
    logic signed [31:0] pos_mem [64];
    logic signed [31:0] mom1_mem [64];
    logic [47:0]        mom2_mem [64];
    logic signed [31:0] lo_mem [64];
    logic signed [31:0] hi_mem [64];
    t_out               exp_fifo [16];
    logic [3:0]         exp_wr, exp_rd;
    int                 exp_cnt;

    function automatic logic signed [31:0] clip32(longint x, ref logic sat);
        if (x > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (x < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_out adam_predict(t_in it);
        t_out        o;
        int          e;
        logic        sat;
        longint      g, sm, p;
        logic [63:0] ga, g2, sv, r, ma, d;
        logic signed [31:0] m, cur;
        e = int'(it.index);
        sat = 1'b0;
        if (it.func == FUNC_LOAD) begin
            lo_mem[e] = it.lower_bound;
            hi_mem[e] = it.upper_bound;
            pos_mem[e] = it.lower_bound;
            mom1_mem[e] = '0;
            mom2_mem[e] = '0;
            cur = pos_mem[e];
        end else if (it.func == FUNC_UPDATE) begin
            if (it.grad_valid) begin
                g = longint'(it.gradient);
                sm = longint'({48'd0, beta1}) * longint'(mom1_mem[e])
                   + (64'sd65536 - longint'({48'd0, beta1})) * g;
                m = clip32(sm >>> 16, sat);
                mom1_mem[e] = m;
                ga = (g < 0) ? -g : g;
                g2 = (ga * ga) >> 8;
                if (g2 > V_MAX) begin
                    g2 = V_MAX;
                    sat = 1'b1;
                end
                sv = {48'd0, beta2} * {16'd0, mom2_mem[e]}
                   + (64'd65536 - {48'd0, beta2}) * g2;
                sv = sv >> 16;
                if (sv > V_MAX) begin
                    sv = V_MAX;
                    sat = 1'b1;
                end
                mom2_mem[e] = sv[47:0];
                r = int_sqrt((sv + {16'd0, eps}) << 14);
                if (r == 0) r = 64'd1;
                ma = (m < 0) ? -longint'(m) : longint'(m);
                d = ({32'd0, rate} * ma) / (r * 64'd32);
                if (d > (64'd1 << 33)) d = 64'd1 << 33;
                p = longint'(pos_mem[e]);
                if (m > 0) p = p - longint'(d);
                else if (m < 0) p = p + longint'(d);
                pos_mem[e] = clip32(p, sat);
            end
            cur = pos_mem[e];
        end else begin
            cur = pos_mem[e];
            if (cur < lo_mem[e]) cur = lo_mem[e];
            if (cur > hi_mem[e]) cur = hi_mem[e];
        end
        o.out_index = it.index;
        o.position = cur;
        o.overflow = sat;
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            beta1 <= 16'd58982;
            beta2 <= 16'd65470;
            rate <= 32'd16777;
            eps <= 48'd1;
            exp_wr = 4'd0;
            exp_rd = 4'd0;
            exp_cnt = 0;
            o_errors <= 0;
            o_pending <= 0;
            o_beats_in <= 0;
            o_beats_out <= 0;
            o_saturated <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_FIRST_DECAY: beta1 <= i_cfg_wdata[15:0];
                    CFG_SECOND_DECAY: beta2 <= i_cfg_wdata[15:0];
                    CFG_STEP_RATE: rate <= i_cfg_wdata[31:0];
                    CFG_ROOT_OFFSET: eps <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_valid) begin
                o_beats_out <= o_beats_out + 1;
                if (exp_cnt == 0) begin
                    $display("%0t: result beat with nothing expected, got %h", $time, o_result);
                    o_errors <= o_errors + 1;
                end else begin
                    want = exp_fifo[exp_rd];
                    exp_rd = exp_rd + 4'd1;
                    exp_cnt = exp_cnt - 1;
                    if (want.overflow) o_saturated <= o_saturated + 1;
                    if (want.out_index !== o_result.out_index ||
                        want.position !== o_result.position ||
                        want.overflow !== o_result.overflow) begin
                        $display("%0t: mismatch idx/pos/ovf expected %0d %h %b got %0d %h %b",
                                 $time, want.out_index, want.position, want.overflow,
                                 o_result.out_index, o_result.position, o_result.overflow);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (start && !busy) begin
                exp_fifo[exp_wr] = adam_predict(i_item);
                exp_wr = exp_wr + 4'd1;
                exp_cnt = exp_cnt + 1;
                o_beats_in <= o_beats_in + 1;
            end
            o_pending <= exp_cnt;
        end
    end
endmodule

// ===== tb/adam_update_with_bound_clamp_core_tb.sv =====
// testbench top for the adam update core: reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps
module adam_update_with_bound_clamp_core_tb;
    import aubc_pkg::*;

    localparam logic [1:0] FUNC_READ = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int PHASE_ITEMS = 312;
    localparam int DRAIN_CYCLES = 150;
    localparam int STALL_LIMIT = 5000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in                  i_item;
    logic                 o_valid;
    t_out                 o_result;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_addr;
    logic [CFG_W-1:0]     i_cfg_wdata;
    int                   errors, pending, beats_in, beats_out, saturated;
    int                   quiet_cycles;
    logic                 loaded [64];

    adam_update_with_bound_clamp_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    aubc_scoreboard i_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata), .o_errors(errors),
        .o_pending(pending), .o_beats_in(beats_in), .o_beats_out(beats_out),
        .o_saturated(saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("adam_update_with_bound_clamp_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(t_in it, int gap_pct);
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_item <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (it.func == FUNC_LOAD) loaded[it.index] = 1'b1;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || (start && !busy)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] b1, logic [15:0] b2, logic [31:0] lr,
                              logic [47:0] eps);
        logic [CFG_W-1:0] vals [4];
        vals[0] = CFG_W'(b1);
        vals[1] = CFG_W'(b2);
        vals[2] = CFG_W'(lr);
        vals[3] = eps;
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= k[1:0];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in make_beat(logic [1:0] f, logic [5:0] idx, logic [31:0] lo,
                                      logic [31:0] hi, logic [31:0] g, logic gv);
        t_in it;
        it.func = f;
        it.index = idx;
        it.lower_bound = lo;
        it.upper_bound = hi;
        it.gradient = g;
        it.grad_valid = gv;
        return it;
    endfunction

    function automatic logic [31:0] pick_gradient();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 131072) - 65536;
            2: return $urandom_range(0, 33554432) - 16777216;
            3: return $urandom_range(0, 64) - 32;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    3: return 32'h1;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic t_in random_beat();
        logic [5:0]  idx;
        int          r;
        logic [31:0] lo, hi;
        idx = 6'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (!loaded[idx] || r < 8) begin
            if ($urandom_range(0, 4) == 0) begin
                lo = $urandom;
                hi = $urandom;
            end else begin
                lo = $urandom_range(0, 2097152) - 1048576;
                hi = lo + $urandom_range(0, 4194304);
            end
            return make_beat(FUNC_LOAD, idx, lo, hi, $urandom, 1'($urandom_range(0, 1)));
        end
        if (r < 75)
            return make_beat(FUNC_UPDATE, idx, $urandom, $urandom, pick_gradient(),
                             $urandom_range(0, 9) != 0);
        if (r < 93)
            return make_beat(FUNC_READ, idx, $urandom, $urandom, $urandom,
                             1'($urandom_range(0, 1)));
        return make_beat(FUNC_SPARE, idx, $urandom, $urandom, $urandom,
                         1'($urandom_range(0, 1)));
    endfunction

    initial begin
        int gap_pct;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= CFG_FIRST_DECAY;
        i_cfg_wdata <= '0;
        for (int k = 0; k < 64; k++) loaded[k] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme bounds, crossed bounds, gradient extremes, invalid gradient
        send_beat(make_beat(FUNC_LOAD, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b1), 0);
        send_beat(make_beat(FUNC_LOAD, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1), 0);
        send_beat(make_beat(FUNC_LOAD, 6'd1, 32'hFFFF_0000, 32'h0001_0000, 0, 1'b0), 0);
        send_beat(make_beat(FUNC_UPDATE, 6'd0, 0, 0, 32'h7FFF_FFFF, 1'b1), 0);
        send_beat(make_beat(FUNC_UPDATE, 6'd0, 0, 0, 32'h8000_0000, 1'b1), 0);
        send_beat(make_beat(FUNC_UPDATE, 6'd0, 0, 0, 32'h8000_0000, 1'b1), 0);
        send_beat(make_beat(FUNC_UPDATE, 6'd1, 0, 0, 32'h1234_5678, 1'b0), 0);
        send_beat(make_beat(FUNC_UPDATE, 6'd1, 0, 0, 32'h0000_0001, 1'b1), 0);
        send_beat(make_beat(FUNC_UPDATE, 6'd1, 0, 0, 32'hFFFF_FFFF, 1'b1), 0);
        send_beat(make_beat(FUNC_UPDATE, 6'd63, 0, 0, 32'h0, 1'b1), 0);
        send_beat(make_beat(FUNC_UPDATE, 6'd63, 0, 0, 32'h7FFF_FFFF, 1'b1), 0);
        send_beat(make_beat(FUNC_READ, 6'd0, 0, 0, 0, 1'b0), 0);
        send_beat(make_beat(FUNC_READ, 6'd63, 0, 0, 0, 1'b0), 0);
        send_beat(make_beat(FUNC_SPARE, 6'd1, 0, 0, 0, 1'b1), 0);
        send_beat(make_beat(FUNC_UPDATE, 6'd1, 0, 0, 32'h0100_0000, 1'b1), 0);
        send_beat(make_beat(FUNC_READ, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            1'b1), 0);
        send_beat(make_beat(FUNC_LOAD, 6'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1), 0);
        send_beat(make_beat(FUNC_READ, 6'd0, 0, 0, 0, 1'b0), 0);

        for (int ph = 0; ph < 3; ph++) begin
            drain();
            case (ph)
                0: write_regs(16'd0, 16'd65535, 32'hFFFF_FFFF, 48'd0);
                1: write_regs(16'd65535, 16'd0, 32'd0, 48'hFFFF_FFFF_FFFF);
                default: write_regs(16'($urandom), 16'($urandom),
                                    32'($urandom_range(0, 33554432)),
                                    {16'd0, $urandom} >> $urandom_range(0, 31));
            endcase
            gap_pct = (ph == 0) ? 19 : (ph == 1) ? 65 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 2) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0 || (start && !busy)) @(posedge i_clk);
                end
                send_beat(random_beat(), gap_pct);
            end
        end

        drain();
        $display("covered %0d items and %0d results, %0d of them saturating,", beats_in,
                 beats_out, saturated);
        $display("over default, extreme low, extreme high and random register settings");
        if (errors == 0) begin
            $display("adam_update_with_bound_clamp_core verification clean");
        end else begin
            $display("adam_update_with_bound_clamp_core verification failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/aubc_pkg.sv
rtl/core/aubc_front.sv
rtl/core/aubc_sqrt.sv
rtl/core/aubc_div.sv
rtl/core/adam_update_with_bound_clamp_core.sv
tb/aubc_scoreboard.sv
tb/adam_update_with_bound_clamp_core_tb.sv
